@@ sv/t3a_pkg.sv @@
// ----------------------------------------------------------------------------
// t3a_pkg
// Shared types and constants for the 3x3 transform apply core.
// ----------------------------------------------------------------------------
package t3a_pkg;

   // width of every element field on the item ports
   localparam int FIELD_W = 32;

   // matrix dimension and row index field width
   localparam int MAT_DIM = 3;
   localparam int ROW_W   = 2;

   // item action codes
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_APPLY = 1'b1;

   // per-stage advance enables, driven by the top-level flow control
   typedef struct packed {
      logic s1_en;   // capture products
      logic s2_en;   // capture rounded sums
      logic out_en;  // capture saturated result
   } stage_ctl_type;

endpackage

@@ sv/t3a_lane.sv @@
// ----------------------------------------------------------------------------
// t3a_lane
// One dot-product lane: three registered products, then the exact sum with
// round half up and the arithmetic shift by the fraction width.
// ----------------------------------------------------------------------------
module t3a_lane #(
   parameter int MATRIX_FRAC = 30,
   parameter int ELEM_WIDTH  = 32
) (
   input  logic                                  clock,
   input  t3a_pkg::stage_ctl_type                ctl,
   input  logic signed [ELEM_WIDTH-1:0]          mat_a,
   input  logic signed [ELEM_WIDTH-1:0]          mat_b,
   input  logic signed [ELEM_WIDTH-1:0]          mat_c,
   input  logic signed [ELEM_WIDTH-1:0]          vec_a,
   input  logic signed [ELEM_WIDTH-1:0]          vec_b,
   input  logic signed [ELEM_WIDTH-1:0]          vec_c,
   output logic signed [2*ELEM_WIDTH+1:0]        sum_ff
);
   import t3a_pkg::*;

   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int SUM_W  = PROD_W + 2;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (MATRIX_FRAC - 1);

   logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff, prod_c_ff;
   logic signed [PROD_W-1:0] prod_a_in, prod_b_in, prod_c_in;
   logic signed [SUM_W-1:0]  total;
   logic signed [SUM_W-1:0]  sum_in;

   // stage 1: element products
   assign prod_a_in = mat_a * vec_a;
   assign prod_b_in = mat_b * vec_b;
   assign prod_c_in = mat_c * vec_c;

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         prod_c_ff <= prod_c_in;
      end
   end

   // stage 2: exact sum, round half up, floor shift
   assign total  = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff) + SUM_W'(prod_c_ff) + HALF;
   assign sum_in = total >>> MATRIX_FRAC;

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         sum_ff <= sum_in;
      end
   end

endmodule

@@ sv/t3a_merge.sv @@
// ----------------------------------------------------------------------------
// t3a_merge
// Merging stage: clips the three lane sums to the element range, combines
// the clip flags and holds the result item in the output register.
// ----------------------------------------------------------------------------
module t3a_merge #(
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                    clock,
   input  t3a_pkg::stage_ctl_type                  ctl,
   input  logic signed [2*ELEM_WIDTH+1:0]          sum_x,
   input  logic signed [2*ELEM_WIDTH+1:0]          sum_y,
   input  logic signed [2*ELEM_WIDTH+1:0]          sum_z,
   output logic signed [t3a_pkg::FIELD_W-1:0]      out_x_ff,
   output logic signed [t3a_pkg::FIELD_W-1:0]      out_y_ff,
   output logic signed [t3a_pkg::FIELD_W-1:0]      out_z_ff,
   output logic                                    saturated_ff
);
   import t3a_pkg::*;

   localparam int SUM_W = 2 * ELEM_WIDTH + 2;
   localparam logic signed [SUM_W-1:0] MAXV =
      {{(SUM_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] MINV =
      {{(SUM_W-ELEM_WIDTH+1){1'b1}}, {(ELEM_WIDTH-1){1'b0}}};

   logic signed [SUM_W-1:0]      sums  [MAT_DIM];
   logic signed [ELEM_WIDTH-1:0] clipv [MAT_DIM];
   logic [MAT_DIM-1:0]           hit;

   assign sums[0] = sum_x;
   assign sums[1] = sum_y;
   assign sums[2] = sum_z;

   // per-lane clip against the signed element range
   always_comb begin
      for (int i = 0; i < MAT_DIM; i++) begin
         if (sums[i] > MAXV) begin
            clipv[i] = MAXV[ELEM_WIDTH-1:0];
            hit[i]   = 1'b1;
         end else if (sums[i] < MINV) begin
            clipv[i] = MINV[ELEM_WIDTH-1:0];
            hit[i]   = 1'b1;
         end else begin
            clipv[i] = sums[i][ELEM_WIDTH-1:0];
            hit[i]   = 1'b0;
         end
      end
   end

   // output register, sign-extended to the field width
   always_ff @(posedge clock) begin
      if (ctl.out_en) begin
         out_x_ff     <= FIELD_W'(clipv[0]);
         out_y_ff     <= FIELD_W'(clipv[1]);
         out_z_ff     <= FIELD_W'(clipv[2]);
         saturated_ff <= |hit;
      end
   end

endmodule

@@ sv/transform_3x3_apply_core.sv @@
// ----------------------------------------------------------------------------
// transform_3x3_apply_core
// 3x3 fixed-point transform applied to a stream of three-element columns.
// ----------------------------------------------------------------------------
// A load item writes one row of the stored matrix in the cycle it is taken
// and gives no result; a load to row three is dropped. An apply item gives
// one result item, A*v or the transpose of A times v as csr_wr_data selects,
// with every sum rounded half up, shifted by MATRIX_FRAC and clipped to the
// signed ELEM_WIDTH range (flagged on rsp_saturated). One item is taken per
// cycle while req_stall is low; an apply result passes through the three
// pipeline registers (products, rounded sums, clipped output). An apply
// may follow a load in the next cycle and sees the new row.
module transform_3x3_apply_core #(
   parameter int MATRIX_FRAC = 30,
   parameter int ELEM_WIDTH  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input item channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [t3a_pkg::ROW_W-1:0]            req_row_index,
   input  logic signed [t3a_pkg::FIELD_W-1:0]   req_elem_a,
   input  logic signed [t3a_pkg::FIELD_W-1:0]   req_elem_b,
   input  logic signed [t3a_pkg::FIELD_W-1:0]   req_elem_c,
   // result item channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [t3a_pkg::FIELD_W-1:0]   rsp_out_x,
   output logic signed [t3a_pkg::FIELD_W-1:0]   rsp_out_y,
   output logic signed [t3a_pkg::FIELD_W-1:0]   rsp_out_z,
   output logic                                 rsp_saturated,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data
);
   import t3a_pkg::*;

   localparam int SUM_W = 2 * ELEM_WIDTH + 2;
   localparam int NUM_ENTRIES = MAT_DIM * MAT_DIM;

   logic signed [ELEM_WIDTH-1:0] mat_ff [NUM_ENTRIES];
   logic signed [ELEM_WIDTH-1:0] elem   [MAT_DIM];
   logic signed [ELEM_WIDTH-1:0] lane_m [MAT_DIM][MAT_DIM];
   logic signed [SUM_W-1:0]      lane_sum [MAT_DIM];
   logic                         transpose_ff;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_ready, s2_ready, s1_ready;
   logic                         accept, load_acc, apply_acc;
   stage_ctl_type                ctl;

   // low ELEM_WIDTH bits of each element field
   assign elem[0] = req_elem_a[ELEM_WIDTH-1:0];
   assign elem[1] = req_elem_b[ELEM_WIDTH-1:0];
   assign elem[2] = req_elem_c[ELEM_WIDTH-1:0];

   // flow control: each stage moves when the one after it has room
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign accept    = req_valid && !req_stall;
   assign load_acc  = accept && (req_action == ACTION_LOAD);
   assign apply_acc = accept && (req_action == ACTION_APPLY);

   assign s1_valid_in  = s1_ready  ? apply_acc   : s1_valid_ff;
   assign s2_valid_in  = s2_ready  ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;

   assign ctl.s1_en  = s1_ready;
   assign ctl.s2_en  = s2_ready;
   assign ctl.out_en = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // transpose select register
   always_ff @(posedge clock) begin
      if (reset) begin
         transpose_ff <= 1'b0;
      end else if (csr_wr_en) begin
         transpose_ff <= csr_wr_data;
      end
   end

   // matrix store, row-major, one row written per load item
   for (genvar r = 0; r < MAT_DIM; r++) begin : g_row
      for (genvar c = 0; c < MAT_DIM; c++) begin : g_col
         always_ff @(posedge clock) begin
            if (reset) begin
               mat_ff[r*MAT_DIM+c] <= '0;
            end else if (load_acc && (req_row_index == ROW_W'(r))) begin
               mat_ff[r*MAT_DIM+c] <= elem[c];
            end
         end

         // lane r takes row r, or column r in transpose mode
         assign lane_m[r][c] = transpose_ff ? mat_ff[c*MAT_DIM+r] : mat_ff[r*MAT_DIM+c];
      end

      t3a_lane #(
         .MATRIX_FRAC (MATRIX_FRAC),
         .ELEM_WIDTH  (ELEM_WIDTH)
      ) u_lane (
         .clock  (clock),
         .ctl    (ctl),
         .mat_a  (lane_m[r][0]),
         .mat_b  (lane_m[r][1]),
         .mat_c  (lane_m[r][2]),
         .vec_a  (elem[0]),
         .vec_b  (elem[1]),
         .vec_c  (elem[2]),
         .sum_ff (lane_sum[r])
      );
   end

   // clip and combine the lane results
   t3a_merge #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_merge (
      .clock        (clock),
      .ctl          (ctl),
      .sum_x        (lane_sum[0]),
      .sum_y        (lane_sum[1]),
      .sum_z        (lane_sum[2]),
      .out_x_ff     (rsp_out_x),
      .out_y_ff     (rsp_out_y),
      .out_z_ff     (rsp_out_z),
      .saturated_ff (rsp_saturated)
   );

   assign rsp_valid = out_valid_ff;

endmodule
